// ===== sv/atmc_pkg.sv =====
// shared constants, types and state codes of the adc trimmed mean calibrator
package atmc_pkg;

  localparam int unsigned SAMPLES = 8;
  localparam int unsigned TRIM    = 1;

  localparam int unsigned SMP_W    = 12;
  localparam int unsigned CNT_W    = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int unsigned SUM_W    = SMP_W + $clog2(SAMPLES + 1);
  localparam bit          SORT_EN  = (SAMPLES > 2 * TRIM) && (SAMPLES > 1);
  localparam int unsigned KEEP_LO  = (SAMPLES > 2 * TRIM) ? TRIM : 0;
  localparam int unsigned KEEP_HI  = (SAMPLES > 2 * TRIM) ? (SAMPLES - TRIM) : SAMPLES;
  localparam int unsigned KEEP_CNT = KEEP_HI - KEEP_LO;

  localparam int unsigned NUM_ANCH  = 5;
  localparam int unsigned ANCH_W    = 24;
  localparam int unsigned ADDR_W    = $clog2(4 * NUM_ANCH);
  localparam int unsigned REG_IDX_W = ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_ANCH_LOW    = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_ANCH_SECOND = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_ANCH_THIRD  = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_ANCH_MIDDLE = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_ANCH_HIGH   = REG_IDX_W'(4);

  localparam logic [ANCH_W-1:0] ANCH_RST [NUM_ANCH] = '{
    24'd1229185, 24'd4097392, 24'd7785041, 24'd11062840, 24'd13520895
  };

  localparam int unsigned MV_W      = 13;
  localparam int unsigned PROD_W    = 2 * MV_W;
  localparam int unsigned CALC_W    = PROD_W + 1;
  localparam int unsigned MV_LIMIT  = 4095;
  localparam int unsigned LIN_SCALE = 3150;
  localparam int unsigned LIN_ROUND = 2047;
  localparam int unsigned LIN_FULL  = 4095;

  localparam int unsigned DIV_W  = 24;
  localparam int unsigned DVS_W  = 12;
  localparam int unsigned DCNT_W = $clog2(DIV_W);

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SORT,
    ST_SUM,
    ST_AVG_GO,
    ST_AVG_WAIT,
    ST_LIN_MUL,
    ST_LIN_GO,
    ST_LIN_WAIT,
    ST_CAL_SEL,
    ST_CAL_MUL,
    ST_CAL_GO,
    ST_CAL_WAIT,
    ST_OUT
  } state_e;

endpackage

// ===== sv/atmc_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
module atmc_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  atmc_pkg::div_req_t  req_i,
  output atmc_pkg::div_rsp_t  rsp_o
);

  logic                              busy_q;
  logic                              done_q;
  logic [atmc_pkg::DCNT_W-1:0]       cnt_q;
  logic [atmc_pkg::DVS_W-1:0]        rem_q;
  logic [atmc_pkg::DVS_W-1:0]        dvs_q;
  logic [atmc_pkg::DIV_W-1:0]        quo_q;

  logic [atmc_pkg::DVS_W:0]          shifted;
  logic [atmc_pkg::DVS_W:0]          diff;
  logic                              ge;
  logic [atmc_pkg::DVS_W-1:0]        rem_n;

  always_comb begin
    shifted = {rem_q, quo_q[atmc_pkg::DIV_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    ge      = (shifted >= {1'b0, dvs_q});
    rem_n   = ge ? diff[atmc_pkg::DVS_W-1:0] : shifted[atmc_pkg::DVS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == atmc_pkg::DCNT_W'(atmc_pkg::DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[atmc_pkg::DIV_W-2:0], ge};
      rem_q <= rem_n;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== sv/adc_trimmed_mean_calibrator.sv =====
// top level: group collection, trimmed mean and piecewise-linear millivolt calibration
//
// sample_i is taken at a rising edge where start is high and busy is low.
// A group holds SAMPLES readings (8 here); every reading but the last of a
// group is taken and busy stays low. The last reading raises
// busy while the group is sorted and reduced:
//   sort: SAMPLES passes of SAMPLES steps through one compare-exchange unit
//   sum:  SAMPLES steps through one adder
//   average, linear scaling and segment division: up to three passes of the
//   shared 24-step divider, with one shared 13x13 multiplier in front of two of them
// The sort (SAMPLES*SAMPLES steps) and the divider passes (24 steps each) make up
// most of the work between the last reading and the result.
// The result (raw_average_o, mv_linear_o, mv_calibrated_o) is shown for one
// cycle with result_valid_o high; the receiver cannot stall it, and busy falls
// in the cycle after that. Anchors sit on the APB-style port at byte address 4*i;
// the user must write them only while the block is idle (the block does not check);
// pready is always high. Reset empties the group and reloads the anchor defaults.
module adc_trimmed_mean_calibrator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [atmc_pkg::SMP_W-1:0]         sample_i,
  output logic                               result_valid_o,
  output logic [atmc_pkg::SMP_W-1:0]         raw_average_o,
  output logic [atmc_pkg::SMP_W-1:0]         mv_linear_o,
  output logic signed [atmc_pkg::MV_W-1:0]   mv_calibrated_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [atmc_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int unsigned N = atmc_pkg::SAMPLES;
  localparam int unsigned IDX1 = (N > 1) ? 1 : 0;

  atmc_pkg::state_e state_q, state_d;

  logic [atmc_pkg::CNT_W-1:0]          count_q;
  logic [atmc_pkg::CNT_W-1:0]          pass_q;
  logic [atmc_pkg::CNT_W-1:0]          step_q;
  logic [atmc_pkg::SMP_W-1:0]          sr_q [N];
  logic [atmc_pkg::SUM_W-1:0]          acc_q;
  logic [atmc_pkg::SMP_W-1:0]          avg_q;
  logic [atmc_pkg::SMP_W-1:0]          lin_q;
  logic signed [atmc_pkg::MV_W-1:0]    cal_q;
  logic signed [atmc_pkg::PROD_W-1:0]  prod_q;
  logic                                direct_q;
  logic [atmc_pkg::SMP_W-1:0]          m0_q;
  logic signed [atmc_pkg::MV_W-1:0]    dv_q;
  logic signed [atmc_pkg::MV_W-1:0]    dm_q;
  logic signed [atmc_pkg::MV_W-1:0]    den_q;
  logic [atmc_pkg::ANCH_W-1:0]         anch_q [atmc_pkg::NUM_ANCH];

  logic                                accept;
  logic                                last_smp;
  logic                                step_last;
  logic                                pass_last;
  logic                                cfg_wr;
  logic [atmc_pkg::REG_IDX_W-1:0]      reg_idx;

  atmc_pkg::div_req_t                  div_req;
  atmc_pkg::div_rsp_t                  div_rsp;

  logic signed [atmc_pkg::MV_W-1:0]    mul_a;
  logic signed [atmc_pkg::MV_W-1:0]    mul_b;
  logic signed [atmc_pkg::PROD_W-1:0]  mul_p;

  logic [atmc_pkg::SMP_W-1:0]          sel_r0, sel_r1, sel_m0, sel_m1;
  logic                                sel_direct;
  logic signed [atmc_pkg::PROD_W-1:0]  prod_abs;
  logic signed [atmc_pkg::MV_W-1:0]    den_abs;
  logic                                den_zero;
  logic signed [atmc_pkg::PROD_W-1:0]  squo;
  logic signed [atmc_pkg::CALC_W-1:0]  mv_sum;
  logic signed [atmc_pkg::MV_W-1:0]    mv_sat;
  logic                                in_keep;

  assign accept    = start && !busy;
  assign last_smp  = (count_q == atmc_pkg::CNT_W'(N - 1));
  assign step_last = (step_q == atmc_pkg::CNT_W'(N - 1));
  assign pass_last = (pass_q == atmc_pkg::CNT_W'(N - 1));
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign reg_idx   = paddr[atmc_pkg::ADDR_W-1:2];
  assign den_zero  = (den_q == '0);
  assign in_keep   = ({1'b0, step_q} >= (atmc_pkg::CNT_W + 1)'(atmc_pkg::KEEP_LO)) &&
                     ({1'b0, step_q} <  (atmc_pkg::CNT_W + 1)'(atmc_pkg::KEEP_HI));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      atmc_pkg::ST_IDLE: begin
        if (accept && last_smp) begin
          state_d = atmc_pkg::SORT_EN ? atmc_pkg::ST_SORT : atmc_pkg::ST_SUM;
        end
      end
      atmc_pkg::ST_SORT: begin
        if (step_last && pass_last) begin
          state_d = atmc_pkg::ST_SUM;
        end
      end
      atmc_pkg::ST_SUM: begin
        if (step_last) begin
          state_d = atmc_pkg::ST_AVG_GO;
        end
      end
      atmc_pkg::ST_AVG_GO:   state_d = atmc_pkg::ST_AVG_WAIT;
      atmc_pkg::ST_AVG_WAIT: begin
        if (div_rsp.done) begin
          state_d = atmc_pkg::ST_LIN_MUL;
        end
      end
      atmc_pkg::ST_LIN_MUL:  state_d = atmc_pkg::ST_LIN_GO;
      atmc_pkg::ST_LIN_GO:   state_d = atmc_pkg::ST_LIN_WAIT;
      atmc_pkg::ST_LIN_WAIT: begin
        if (div_rsp.done) begin
          state_d = atmc_pkg::ST_CAL_SEL;
        end
      end
      atmc_pkg::ST_CAL_SEL:  state_d = atmc_pkg::ST_CAL_MUL;
      atmc_pkg::ST_CAL_MUL:  state_d = atmc_pkg::ST_CAL_GO;
      atmc_pkg::ST_CAL_GO: begin
        state_d = (direct_q || den_zero) ? atmc_pkg::ST_OUT : atmc_pkg::ST_CAL_WAIT;
      end
      atmc_pkg::ST_CAL_WAIT: begin
        if (div_rsp.done) begin
          state_d = atmc_pkg::ST_OUT;
        end
      end
      atmc_pkg::ST_OUT:      state_d = atmc_pkg::ST_IDLE;
      default:               state_d = atmc_pkg::ST_IDLE;
    endcase
  end

  // outputs and divider request
  always_comb begin
    busy             = (state_q != atmc_pkg::ST_IDLE);
    result_valid_o   = (state_q == atmc_pkg::ST_OUT);
    div_req.start    = 1'b0;
    div_req.dividend = prod_abs[atmc_pkg::DIV_W-1:0];
    div_req.divisor  = den_abs[atmc_pkg::DVS_W-1:0];
    unique case (state_q)
      atmc_pkg::ST_AVG_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = atmc_pkg::DIV_W'(acc_q);
        div_req.divisor  = atmc_pkg::DVS_W'(atmc_pkg::KEEP_CNT);
      end
      atmc_pkg::ST_LIN_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_q[atmc_pkg::DIV_W-1:0];
        div_req.divisor  = atmc_pkg::DVS_W'(atmc_pkg::LIN_FULL);
      end
      atmc_pkg::ST_CAL_GO: begin
        div_req.start    = !direct_q && !den_zero;
      end
      default: begin
      end
    endcase
  end

  // shared multiplier
  always_comb begin
    if (state_q == atmc_pkg::ST_LIN_MUL) begin
      mul_a = $signed({1'b0, avg_q});
      mul_b = atmc_pkg::MV_W'(atmc_pkg::LIN_SCALE);
    end else begin
      mul_a = dv_q;
      mul_b = dm_q;
    end
    mul_p = mul_a * mul_b;
  end

  // segment selection
  always_comb begin
    sel_direct = 1'b0;
    sel_r0 = anch_q[3][atmc_pkg::SMP_W-1:0];
    sel_r1 = anch_q[4][atmc_pkg::SMP_W-1:0];
    sel_m0 = anch_q[3][atmc_pkg::ANCH_W-1:atmc_pkg::SMP_W];
    sel_m1 = anch_q[4][atmc_pkg::ANCH_W-1:atmc_pkg::SMP_W];
    priority if (avg_q <= anch_q[0][atmc_pkg::SMP_W-1:0]) begin
      sel_direct = 1'b1;
      sel_m0 = anch_q[0][atmc_pkg::ANCH_W-1:atmc_pkg::SMP_W];
    end else if (avg_q >= anch_q[4][atmc_pkg::SMP_W-1:0]) begin
      sel_direct = 1'b1;
      sel_m0 = anch_q[4][atmc_pkg::ANCH_W-1:atmc_pkg::SMP_W];
    end else if (avg_q <= anch_q[1][atmc_pkg::SMP_W-1:0]) begin
      sel_r0 = anch_q[0][atmc_pkg::SMP_W-1:0];
      sel_r1 = anch_q[1][atmc_pkg::SMP_W-1:0];
      sel_m0 = anch_q[0][atmc_pkg::ANCH_W-1:atmc_pkg::SMP_W];
      sel_m1 = anch_q[1][atmc_pkg::ANCH_W-1:atmc_pkg::SMP_W];
    end else if (avg_q <= anch_q[2][atmc_pkg::SMP_W-1:0]) begin
      sel_r0 = anch_q[1][atmc_pkg::SMP_W-1:0];
      sel_r1 = anch_q[2][atmc_pkg::SMP_W-1:0];
      sel_m0 = anch_q[1][atmc_pkg::ANCH_W-1:atmc_pkg::SMP_W];
      sel_m1 = anch_q[2][atmc_pkg::ANCH_W-1:atmc_pkg::SMP_W];
    end else if (avg_q <= anch_q[3][atmc_pkg::SMP_W-1:0]) begin
      sel_r0 = anch_q[2][atmc_pkg::SMP_W-1:0];
      sel_r1 = anch_q[3][atmc_pkg::SMP_W-1:0];
      sel_m0 = anch_q[2][atmc_pkg::ANCH_W-1:atmc_pkg::SMP_W];
      sel_m1 = anch_q[3][atmc_pkg::ANCH_W-1:atmc_pkg::SMP_W];
    end else begin
    end
  end

  // signed division around the unsigned divider
  always_comb begin
    prod_abs = prod_q[atmc_pkg::PROD_W-1] ? -prod_q : prod_q;
    den_abs  = den_q[atmc_pkg::MV_W-1] ? -den_q : den_q;
    squo     = $signed({2'b00, div_rsp.quotient});
    if (prod_q[atmc_pkg::PROD_W-1] ^ den_q[atmc_pkg::MV_W-1]) begin
      squo = -squo;
    end
    mv_sum = $signed({{(atmc_pkg::CALC_W - atmc_pkg::SMP_W){1'b0}}, m0_q}) +
             $signed({squo[atmc_pkg::PROD_W-1], squo});
    priority if (mv_sum > $signed(atmc_pkg::CALC_W'(atmc_pkg::MV_LIMIT))) begin
      mv_sat = atmc_pkg::MV_W'(atmc_pkg::MV_LIMIT);
    end else if (mv_sum < -$signed(atmc_pkg::CALC_W'(atmc_pkg::MV_LIMIT))) begin
      mv_sat = -$signed(atmc_pkg::MV_W'(atmc_pkg::MV_LIMIT));
    end else begin
      mv_sat = mv_sum[atmc_pkg::MV_W-1:0];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= atmc_pkg::ST_IDLE;
      count_q <= '0;
      pass_q  <= '0;
      step_q  <= '0;
      for (int i = 0; i < atmc_pkg::NUM_ANCH; i++) begin
        anch_q[i] <= atmc_pkg::ANCH_RST[i];
      end
    end else begin
      state_q <= state_d;
      if (accept) begin
        count_q <= last_smp ? '0 : count_q + 1'b1;
        pass_q  <= '0;
        step_q  <= '0;
      end
      if (state_q == atmc_pkg::ST_SORT || state_q == atmc_pkg::ST_SUM) begin
        step_q <= step_last ? '0 : step_q + 1'b1;
        if (step_last) begin
          pass_q <= pass_q + 1'b1;
        end
      end
      if (cfg_wr) begin
        unique case (reg_idx)
          atmc_pkg::REG_ANCH_LOW:    anch_q[0] <= pwdata[atmc_pkg::ANCH_W-1:0];
          atmc_pkg::REG_ANCH_SECOND: anch_q[1] <= pwdata[atmc_pkg::ANCH_W-1:0];
          atmc_pkg::REG_ANCH_THIRD:  anch_q[2] <= pwdata[atmc_pkg::ANCH_W-1:0];
          atmc_pkg::REG_ANCH_MIDDLE: anch_q[3] <= pwdata[atmc_pkg::ANCH_W-1:0];
          atmc_pkg::REG_ANCH_HIGH:   anch_q[4] <= pwdata[atmc_pkg::ANCH_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      atmc_pkg::ST_IDLE: begin
        if (accept) begin
          sr_q[count_q] <= sample_i;
          acc_q         <= '0;
        end
      end
      atmc_pkg::ST_SORT: begin
        if (!step_last) begin
          if (sr_q[0] > sr_q[IDX1]) begin
            sr_q[0]   <= sr_q[0];
            sr_q[N-1] <= sr_q[IDX1];
          end else begin
            sr_q[0]   <= sr_q[IDX1];
            sr_q[N-1] <= sr_q[0];
          end
          for (int i = 1; i < N - 1; i++) begin
            sr_q[i] <= sr_q[i+1];
          end
        end else begin
          for (int i = 0; i < N - 1; i++) begin
            sr_q[i] <= sr_q[i+1];
          end
          sr_q[N-1] <= sr_q[0];
        end
      end
      atmc_pkg::ST_SUM: begin
        for (int i = 0; i < N - 1; i++) begin
          sr_q[i] <= sr_q[i+1];
        end
        sr_q[N-1] <= sr_q[0];
        if (in_keep) begin
          acc_q <= acc_q + atmc_pkg::SUM_W'(sr_q[0]);
        end
      end
      atmc_pkg::ST_AVG_WAIT: begin
        if (div_rsp.done) begin
          avg_q <= div_rsp.quotient[atmc_pkg::SMP_W-1:0];
        end
      end
      atmc_pkg::ST_LIN_MUL: begin
        prod_q <= mul_p + atmc_pkg::PROD_W'(atmc_pkg::LIN_ROUND);
      end
      atmc_pkg::ST_LIN_WAIT: begin
        if (div_rsp.done) begin
          lin_q <= div_rsp.quotient[atmc_pkg::SMP_W-1:0];
        end
      end
      atmc_pkg::ST_CAL_SEL: begin
        direct_q <= sel_direct;
        m0_q     <= sel_m0;
        dv_q     <= $signed({1'b0, avg_q}) - $signed({1'b0, sel_r0});
        dm_q     <= $signed({1'b0, sel_m1}) - $signed({1'b0, sel_m0});
        den_q    <= $signed({1'b0, sel_r1}) - $signed({1'b0, sel_r0});
      end
      atmc_pkg::ST_CAL_MUL: begin
        prod_q <= mul_p;
      end
      atmc_pkg::ST_CAL_GO: begin
        if (direct_q || den_zero) begin
          cal_q <= $signed({1'b0, m0_q});
        end
      end
      atmc_pkg::ST_CAL_WAIT: begin
        if (div_rsp.done) begin
          cal_q <= mv_sat;
        end
      end
      default: begin
      end
    endcase
  end

  atmc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // register read
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      atmc_pkg::REG_ANCH_LOW:    prdata = 32'(anch_q[0]);
      atmc_pkg::REG_ANCH_SECOND: prdata = 32'(anch_q[1]);
      atmc_pkg::REG_ANCH_THIRD:  prdata = 32'(anch_q[2]);
      atmc_pkg::REG_ANCH_MIDDLE: prdata = 32'(anch_q[3]);
      atmc_pkg::REG_ANCH_HIGH:   prdata = 32'(anch_q[4]);
      default:                   prdata = '0;
    endcase
  end

  assign pready          = 1'b1;
  assign raw_average_o   = avg_q;
  assign mv_linear_o     = lin_q;
  assign mv_calibrated_o = cal_q;

endmodule
